// ===== design/utf8_hiragana_to_katakana_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef UTF8_HIRAGANA_TO_KATAKANA_TOP_DEFINES_SVH
`define UTF8_HIRAGANA_TO_KATAKANA_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define U8HK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8hk checker: property failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define U8HK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8hk checker: property failed");

`endif

// ===== design/u8hk_pkg.sv =====
package u8hk_pkg;

    localparam int unsigned PointW = 21;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW = 2;

    localparam logic [PointW-1:0] HiraFirst = 21'h003041;
    localparam logic [PointW-1:0] HiraLast = 21'h003096;
    localparam logic [PointW-1:0] KataShift = 21'h000060;
    localparam logic [PointW-1:0] Max1Byte = 21'h00007f;
    localparam logic [PointW-1:0] Max2Byte = 21'h0007ff;
    localparam logic [PointW-1:0] Max3Byte = 21'h00ffff;

    // Encoded length minus one.
    typedef enum logic [1:0] {
        LEN_1 = 2'd0,
        LEN_2 = 2'd1,
        LEN_3 = 2'd2,
        LEN_4 = 2'd3
    } enc_len_t;

    // One decoded event: a complete code point or an error marker.
    typedef struct packed {
        logic [PointW-1:0] point;
        logic              last;
        logic              bad;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== design/u8hk_front.sv =====
module u8hk_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  u8hk_pkg::queue_status_t q_status,
    output logic              in_ready,
    output logic              push,
    output u8hk_pkg::entry_t  push_entry
);

    logic [u8hk_pkg::PointW-1:0] partial_reg, partial_next;
    logic [1:0]                  pending_reg, pending_next;
    logic                        discard_reg, discard_next;
    logic                        accept;
    logic [u8hk_pkg::PointW-1:0] shifted;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign shifted  = {partial_reg[u8hk_pkg::PointW-7:0], in_byte[5:0]};

    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        discard_next = discard_reg;
        push         = 1'b0;
        push_entry   = '{point: '0, last: in_last, bad: 1'b1};
        if (accept)
        begin
            if (discard_reg)
            begin
                if (in_last)
                begin
                    discard_next = 1'b0;
                end
            end
            else if (pending_reg == 2'd0)
            begin
                if (!in_byte[7])
                begin
                    push             = 1'b1;
                    push_entry.point = {13'd0, in_byte};
                    push_entry.bad   = 1'b0;
                end
                else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110
                         || in_byte[7:3] == 5'b11110)
                begin
                    if (in_last)
                    begin
                        // A lead byte that closes the text is a truncation.
                        push         = 1'b1;
                        partial_next = '0;
                        pending_next = 2'd0;
                    end
                    else if (in_byte[7:5] == 3'b110)
                    begin
                        partial_next = {16'd0, in_byte[4:0]};
                        pending_next = 2'd1;
                    end
                    else if (in_byte[7:4] == 4'b1110)
                    begin
                        partial_next = {17'd0, in_byte[3:0]};
                        pending_next = 2'd2;
                    end
                    else
                    begin
                        partial_next = {18'd0, in_byte[2:0]};
                        pending_next = 2'd3;
                    end
                end
                else
                begin
                    push         = 1'b1;
                    partial_next = '0;
                    discard_next = !in_last;
                end
            end
            else if (in_byte[7:6] != 2'b10)
            begin
                // The offending byte is consumed, not read as a new lead.
                push         = 1'b1;
                partial_next = '0;
                pending_next = 2'd0;
                discard_next = !in_last;
            end
            else if (pending_reg == 2'd1)
            begin
                push             = 1'b1;
                push_entry.point = shifted;
                push_entry.bad   = 1'b0;
                partial_next     = '0;
                pending_next     = 2'd0;
            end
            else if (in_last)
            begin
                push         = 1'b1;
                partial_next = '0;
                pending_next = 2'd0;
            end
            else
            begin
                partial_next = shifted;
                pending_next = pending_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= 2'd0;
            discard_reg <= 1'b0;
        end
        else
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
            discard_reg <= discard_next;
        end
    end

endmodule

// ===== design/u8hk_queue.sv =====
module u8hk_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  u8hk_pkg::entry_t       push_entry,
    input  logic                   pop,
    output u8hk_pkg::entry_t       head,
    output u8hk_pkg::queue_status_t status
);

    u8hk_pkg::entry_t store_reg [u8hk_pkg::QueueDepth];
    logic [u8hk_pkg::QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [u8hk_pkg::QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [u8hk_pkg::QueuePtrW:0]   count_reg, count_next;

    assign head         = store_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (u8hk_pkg::QueuePtrW+1)'(u8hk_pkg::QueueDepth));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/u8hk_back.sv =====
module u8hk_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  u8hk_pkg::entry_t       head,
    input  u8hk_pkg::queue_status_t q_status,
    output logic                   pop,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [7:0]             out_byte,
    output logic                   out_char_last,
    output logic                   out_text_done,
    output logic                   out_bad
);

    logic [u8hk_pkg::PointW-1:0] cp;
    u8hk_pkg::enc_len_t          len;
    logic [1:0]                  idx_reg, idx_next;
    logic [1:0]                  remain;
    logic                        valid_reg, valid_next;
    logic [7:0]                  byte_reg, byte_next;
    logic                        char_last_reg, char_last_next;
    logic                        text_done_reg, text_done_next;
    logic                        bad_reg, bad_next;
    logic                        load;
    logic                        fin;

    always_comb
    begin
        cp = head.point;
        if (cp >= u8hk_pkg::HiraFirst && cp <= u8hk_pkg::HiraLast)
        begin
            cp = cp + u8hk_pkg::KataShift;
        end
        if (cp <= u8hk_pkg::Max1Byte)
        begin
            len = u8hk_pkg::LEN_1;
        end
        else if (cp <= u8hk_pkg::Max2Byte)
        begin
            len = u8hk_pkg::LEN_2;
        end
        else if (cp <= u8hk_pkg::Max3Byte)
        begin
            len = u8hk_pkg::LEN_3;
        end
        else
        begin
            len = u8hk_pkg::LEN_4;
        end
    end

    assign remain = len - idx_reg;
    assign fin    = head.bad || (remain == 2'd0);
    assign load   = !valid_reg || out_ready;
    assign pop    = load && !q_status.empty && fin;

    always_comb
    begin
        byte_next      = byte_reg;
        char_last_next = char_last_reg;
        text_done_next = text_done_reg;
        bad_next       = bad_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            valid_next = !q_status.empty;
            if (!q_status.empty)
            begin
                char_last_next = fin;
                text_done_next = fin && head.last;
                bad_next       = head.bad;
                idx_next       = fin ? 2'd0 : idx_reg + 2'd1;
                if (head.bad)
                begin
                    byte_next = 8'h00;
                end
                else if (idx_reg == 2'd0)
                begin
                    unique case (len)
                        u8hk_pkg::LEN_1: byte_next = {1'b0, cp[6:0]};
                        u8hk_pkg::LEN_2: byte_next = {3'b110, cp[10:6]};
                        u8hk_pkg::LEN_3: byte_next = {4'b1110, cp[15:12]};
                        u8hk_pkg::LEN_4: byte_next = {5'b11110, cp[20:18]};
                        default:         byte_next = 8'h00;
                    endcase
                end
                else
                begin
                    case (remain)
                        2'd0:    byte_next = {2'b10, cp[5:0]};
                        2'd1:    byte_next = {2'b10, cp[11:6]};
                        default: byte_next = {2'b10, cp[17:12]};
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        char_last_reg <= char_last_next;
        text_done_reg <= text_done_next;
        bad_reg       <= bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign out_char_last = char_last_reg;
    assign out_text_done = text_done_reg;
    assign out_bad       = bad_reg;

endmodule

// ===== design/utf8_hiragana_to_katakana_top.sv =====
// Channel  Direction  tdata           tuser                      tlast
// s_*      in         in_byte [7:0]   -                          text_last
// m_*      out        out_byte [7:0]  char_last [0], bad_input [1] text_done
//
// The decoder takes one input byte per cycle while the four-entry event queue has room.
// The encoder emits one output byte per cycle while m_tready is high and an event waits;
// a character yields one to four bytes, its re-encoded form, from the output register.
// A character's first output byte passes the event queue, then the output register.
// Reset clears all control state. An output stall fills the queue and then drops
// s_tready; bytes dropped after an error are taken but push nothing into the queue.
module utf8_hiragana_to_katakana_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] char_last, [1] bad_input
    output logic       m_tlast
);

    logic                    push;
    logic                    pop;
    u8hk_pkg::entry_t        push_entry;
    u8hk_pkg::entry_t        head;
    u8hk_pkg::queue_status_t q_status;

    u8hk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .q_status   (q_status),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    u8hk_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    u8hk_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_byte      (m_tdata),
        .out_char_last (m_tuser[0]),
        .out_text_done (m_tlast),
        .out_bad       (m_tuser[1])
    );

endmodule

// ===== design/u8hk_checker.sv =====
`include "utf8_hiragana_to_katakana_top_defines.svh"

module u8hk_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // An error request carries a zero byte and closes its character.
    `U8HK_ASSERT_IMP(a_bad_zero, m_tvalid && m_tuser[1], m_tdata == 8'h00 && m_tuser[0])

    // The end of a text always falls on the end of a character.
    `U8HK_ASSERT_IMP(a_done_char, m_tvalid && m_tlast, m_tuser[0])

    // A byte that is not the last of its character is a lead or continuation byte.
    `U8HK_ASSERT_IMP(a_multi_high, m_tvalid && !m_tuser[0], m_tdata[7])

    // A stalled output request holds its value.
    `U8HK_ASSERT_NXT(a_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind utf8_hiragana_to_katakana_top u8hk_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int IdleLimit = 4000;
    localparam int MaxReported = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       char_last;
        logic       text_done;
        logic       bad;
    } utf8_out_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    // Decoder state of the predictor.
    logic [20:0] dec_point;
    logic [1:0]  dec_pending;
    logic        dec_dropping;

    utf8_out_t   recoded_q[$];
    logic [7:0]  text_q[$];

    int mismatch_count;
    int items_taken;
    int idle_cycles;
    int burst_left;
    bit gaps_on;
    int rx_hold_cycles;
    int rx_mode;
    int rx_phase_left;

    utf8_hiragana_to_katakana_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void add_result(input utf8_out_t r);
        recoded_q = {recoded_q, r};
    endfunction

    function automatic void add_text_byte(input logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    function automatic void drop_text_byte();
        text_q = text_q[0:$-1];
    endfunction

    function automatic void push_error(input logic last);
        add_result('{data: 8'h00, char_last: 1'b1, text_done: last, bad: 1'b1});
        dec_point = '0;
        dec_pending = '0;
        dec_dropping = !last;
    endfunction

    // Shifts hiragana to katakana and writes the point out in its shortest form.
    function automatic void push_encoded(input logic [20:0] point_in, input logic last);
        logic [20:0] cp;
        logic [7:0]  enc [4];
        int          n;
        cp = point_in;
        if (cp >= u8hk_pkg::HiraFirst && cp <= u8hk_pkg::HiraLast)
            cp = cp + u8hk_pkg::KataShift;
        if (cp <= u8hk_pkg::Max1Byte)
        begin
            enc[0] = cp[7:0];
            n = 1;
        end
        else if (cp <= u8hk_pkg::Max2Byte)
        begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            n = 2;
        end
        else if (cp <= u8hk_pkg::Max3Byte)
        begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            n = 3;
        end
        else
        begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
            n = 4;
        end
        for (int k = 0; k < n; k++)
            add_result('{data: enc[k], char_last: (k == n - 1),
                         text_done: (k == n - 1) && last, bad: 1'b0});
    endfunction

    // Returns 0 when the byte is dropped as part of a bad text.
    function automatic bit recode_byte(input logic [7:0] b, input logic last);
        if (dec_dropping)
        begin
            if (last)
                dec_dropping = 1'b0;
            return 1'b0;
        end
        if (dec_pending == 2'd0)
        begin
            if (b[7] == 1'b0)
                push_encoded({13'd0, b}, last);
            else
            begin
                if (b[7:5] == 3'b110)
                begin
                    dec_point = {16'd0, b[4:0]};
                    dec_pending = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    dec_point = {17'd0, b[3:0]};
                    dec_pending = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    dec_point = {18'd0, b[2:0]};
                    dec_pending = 2'd3;
                end
                else
                begin
                    push_error(last);
                    return 1'b1;
                end
                if (last)
                    push_error(last);
            end
            return 1'b1;
        end
        // A byte that is not a continuation is consumed by the error.
        if (b[7:6] != 2'b10)
        begin
            push_error(last);
            return 1'b1;
        end
        dec_point = {dec_point[14:0], b[5:0]};
        dec_pending = dec_pending - 2'd1;
        if (dec_pending == 2'd0)
        begin
            push_encoded(dec_point, last);
            dec_point = '0;
        end
        else if (last)
            push_error(last);
        return 1'b1;
    endfunction

    function automatic int min_len(input logic [20:0] cp);
        if (cp <= 21'h7f)
            return 1;
        if (cp <= 21'h7ff)
            return 2;
        if (cp <= 21'hffff)
            return 3;
        return 4;
    endfunction

    // Encodes a point with the given length, which may be longer than needed.
    function automatic void add_char(input logic [20:0] cp, input int len);
        case (len)
            1: add_text_byte({1'b0, cp[6:0]});
            2:
            begin
                add_text_byte({3'b110, cp[10:6]});
                add_text_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                add_text_byte({4'b1110, cp[15:12]});
                add_text_byte({2'b10, cp[11:6]});
                add_text_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                add_text_byte({5'b11110, cp[20:18]});
                add_text_byte({2'b10, cp[17:12]});
                add_text_byte({2'b10, cp[11:6]});
                add_text_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic logic [20:0] rand_point();
        case ($urandom_range(0, 9))
            0, 1:       return 21'($urandom_range(0, 'h7f));
            2, 3, 4, 5: return 21'($urandom_range('h3040, 'h3097));
            6:          return 21'($urandom_range('h80, 'h7ff));
            7:          return 21'($urandom_range('h800, 'hffff));
            8:          return 21'($urandom_range('h10000, 'h1fffff));
            default:    return 21'($urandom_range(0, 'h1fffff));
        endcase
    endfunction

    function automatic void add_rand_chars(input int count);
        logic [20:0] cp;
        int          len;
        for (int i = 0; i < count; i++)
        begin
            cp = rand_point();
            len = min_len(cp);
            // Now and then an overlong form, which must come out canonical.
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(len, 4);
            add_char(cp, len);
        end
    endfunction

    // Mostly well-formed texts; the rest truncated, broken or plain noise.
    function automatic void build_text();
        logic [20:0] cp;
        int          len;
        add_rand_chars($urandom_range(1, 6));
        case ($urandom_range(0, 9))
            0:
            begin
                cp = 21'($urandom_range('h80, 'h1fffff));
                len = min_len(cp);
                add_char(cp, len);
                repeat ($urandom_range(1, len - 1))
                    drop_text_byte();
            end
            1:
            begin
                add_text_byte(8'($urandom_range('hc0, 'hf7)));
                add_text_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 'h7f))
                                                   : 8'($urandom_range('hc0, 'hff)));
                add_rand_chars($urandom_range(0, 3));
            end
            2:
            begin
                add_text_byte($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hbf))
                                                   : 8'($urandom_range('hf8, 'hff)));
                add_rand_chars($urandom_range(0, 3));
            end
            3:
            begin
                text_q.delete();
                repeat ($urandom_range(1, 8))
                    add_text_byte(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (gaps_on && burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = last;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        void'(recode_byte(b, last));
        items_taken++;
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (recoded_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_extremes();
        add_char(21'h00, 1);
        add_char(21'h7f, 1);
        send_text();
    endtask

    task automatic test_kana_shift();
        add_char(u8hk_pkg::HiraFirst, 3);
        add_char(u8hk_pkg::HiraLast, 3);
        add_char(u8hk_pkg::HiraLast + 21'd1, 3);
        send_text();
    endtask

    task automatic test_lengths();
        add_char(21'h7ff, 2);
        add_char(21'h1fffff, 4);
        add_char(21'h41, 2);
        send_text();
    endtask

    task automatic test_errors();
        // Invalid lead byte that also ends the text.
        add_text_byte(8'h80);
        send_text();
        // Invalid lead byte, then the rest of the text is dropped.
        add_text_byte(8'hff);
        add_text_byte(8'h41);
        send_text();
        // Text that ends on a lead byte.
        add_text_byte(8'he3);
        send_text();
        // Bad continuation byte carrying the end of the text.
        add_text_byte(8'hc3);
        add_text_byte(8'h41);
        send_text();
    endtask

    task automatic test_random_texts(input int count);
        int stop_at;
        stop_at = items_taken + count;
        while (items_taken < stop_at)
        begin
            if ($urandom_range(0, 15) == 0)
                gaps_on = !gaps_on;
            build_text();
            send_text();
        end
    endtask

    // The output is held off long enough for the block to stop taking input.
    task automatic test_backpressure();
        gaps_on = 1'b0;
        rx_hold_cycles = 300;
        test_random_texts(60);
        gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (4)
        begin
            test_random_texts(25);
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        dec_point = '0;
        dec_pending = '0;
        dec_dropping = 1'b0;
        mismatch_count = 0;
        items_taken = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        rx_hold_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extremes();
        test_kana_shift();
        test_lengths();
        test_errors();
        test_random_texts(270);
        test_backpressure();
        test_drain_pause();
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && recoded_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // The receiver switches between random stall patterns, one pattern per phase.
    initial
    begin
        m_tready = 1'b0;
        rx_mode = 0;
        rx_phase_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_tready = 1'b0;
                rx_hold_cycles--;
            end
            else
            begin
                if (rx_phase_left == 0)
                begin
                    rx_mode = $urandom_range(0, 3);
                    rx_phase_left = $urandom_range(16, 96);
                end
                rx_phase_left--;
                case (rx_mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = ($urandom_range(0, 3) != 0);
                    2:       m_tready = $urandom_range(0, 1);
                    default: m_tready = (rx_phase_left % 3 != 0);
                endcase
            end
        end
    end

    function automatic void note_mismatch(input string why, input utf8_out_t want,
                                          input utf8_out_t got);
        mismatch_count++;
        if (mismatch_count <= MaxReported)
            $display("%0t %0s: expected %02h cl %b td %b bad %b, got %02h cl %b td %b bad %b",
                     $realtime, why, want.data, want.char_last, want.text_done, want.bad,
                     got.data, got.char_last, got.text_done, got.bad);
    endfunction

    // Each output request is matched against the oldest predicted byte.
    always @(posedge clk)
    begin : check_output
        utf8_out_t got;
        utf8_out_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got = '{data: m_tdata, char_last: m_tuser[0], text_done: m_tlast,
                    bad: m_tuser[1]};
            if (recoded_q.size() == 0)
                note_mismatch("unexpected output", '0, got);
            else
            begin
                want = recoded_q.pop_front();
                if (got.data !== want.data || got.char_last !== want.char_last ||
                    got.text_done !== want.text_done || got.bad !== want.bad)
                    note_mismatch("wrong output", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IdleLimit)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
